// File: sv/deq_pkg.sv
// Shared definitions for the double-ended queue: request and status codes,
// and the command and status groups between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package deq_pkg;

  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam int WORD_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch an accepted request
    logic exec;         // check and apply the latched request
    logic rd_first;     // read the front element
    logic rd_next;      // read the following element
    logic load_single;  // present the single status-only result
    logic load_elem;    // present the element held in the read register
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;       // the last request failed
    logic empty;     // no element stored
    logic idx_last;  // the read register holds the back element
    logic out_free;  // the output register can take a result this cycle
  } deq_sts_t;

endpackage

// File: sv/deq_dp.sv
// Datapath of the double-ended queue: ring storage, front pointer,
// occupancy, request capture, read register and the output register.
// Depends on deq_pkg for codes and the command and status groups.
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  deq_cmd_t            cmd,
  output deq_sts_t            sts,
  input  logic [1:0]          req_type,
  input  logic [WORD_W-1:0]   push_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                element_valid,
  output logic [WORD_W-1:0]   element,
  output logic [CW-1:0]       count,
  output logic                last
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [1:0]        req;
  logic [WORD_W-1:0] val;
  logic [1:0]        res_status;
  logic [AW-1:0]     front;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     idx;

  logic              is_push;
  logic              full;
  logic              empty;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [CW-1:0]     idx_inc;

  // Ring position offset from the front, with the sum known below 2*DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] offs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offs);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign is_push   = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = ring_add(front, CW'(1));
  assign idx_inc   = idx + CW'(1);

  assign we    = cmd.exec && is_push && !full;
  assign waddr = (req == REQ_PUSH_FRONT) ? front_dec : ring_add(front, occ);
  assign re    = cmd.rd_first || cmd.rd_next;
  assign raddr = cmd.rd_first ? front : ring_add(front, idx_inc);

  assign sts.err      = (res_status != ST_OK);
  assign sts.empty    = empty;
  assign sts.idx_last = (idx_inc == occ);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= val;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= req_type;
      val <= push_value;
    end
    if (cmd.rd_first) begin
      idx <= '0;
    end else if (cmd.rd_next) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      occ        <= '0;
      res_status <= ST_OK;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (full) begin
          res_status <= ST_OVERFLOW;
        end else begin
          res_status <= ST_OK;
          occ        <= occ + CW'(1);
          if (req == REQ_PUSH_FRONT) begin
            front <= front_dec;
          end
        end
      end else begin
        if (empty) begin
          res_status <= ST_UNDERFLOW;
        end else begin
          res_status <= ST_OK;
          occ        <= occ - CW'(1);
          if (occ == CW'(1)) begin
            front <= '0;
          end else if (req == REQ_POP_FRONT) begin
            front <= front_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_elem) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      status        <= res_status;
      element_valid <= 1'b0;
      element       <= '0;
      count         <= occ;
      last          <= 1'b1;
    end else if (cmd.load_elem) begin
      status        <= ST_OK;
      element_valid <= 1'b1;
      element       <= rdata;
      count         <= occ;
      last          <= sts.idx_last;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy exceeds the ring depth");

  a_front_home: assert property (@(posedge clk) disable iff (rst)
    occ == '0 |-> front == '0)
    else $error("front pointer not at zero while empty");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_single, cmd.load_elem, cmd.exec}))
    else $error("conflicting datapath commands");

  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_valid |-> status == ST_OK)
    else $error("element result with an error status");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_single || cmd.load_elem |-> sts.out_free)
    else $error("output register overwritten before it was taken");

endmodule

// File: sv/deq_ctrl.sv
// Controller of the double-ended queue: sequences capture, execution and
// the front-to-back listing of the contents, one result at a time.
// Depends on deq_pkg for the command and status groups.
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_sts_t sts,
  output deq_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SINGLE = 3'd3;
  localparam logic [2:0] S_SEND   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.err || sts.empty) begin
          state_next = S_SINGLE;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_SEND;
        end
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.load_elem = 1'b1;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit words in a ring of DEPTH slots.
// A request is captured in idle, applied in EXEC, checked in CHECK, and its results
// registered from SINGLE or SEND as the output frees; no new request is taken
// until the last is loaded; one-port ring reads list one element a cycle if unstalled.
// Reset (rst, synchronous, active high) empties the queue at once; no clearing pass.
// Depends on deq_pkg, deq_ctrl and deq_dp.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic signed [WORD_W-1:0]          push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic                              element_valid,
  output logic signed [WORD_W-1:0]          element,
  output logic [$clog2(DEPTH + 1)-1:0]      count,
  output logic                              last
);

  // The controller owns sequencing: it takes one request at a time, has the
  // datapath apply it, then either presents a single status-only result (an
  // error, or an empty queue after success) or walks the ring from the front.
  deq_cmd_t cmd;
  deq_sts_t sts;

  // Push and element data as unsigned words at the datapath ports.
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] elem_word;

  assign push_word = push_value;
  assign element   = elem_word;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the ring, pointers and the output register; while a
  // result waits on out_stall the listing simply pauses, the read register
  // holding the next element until the output register frees up.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .push_value    (push_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_valid (element_valid),
    .element       (elem_word),
    .count         (count),
    .last          (last)
  );

endmodule
